// ===== design/tlb_page_table_translator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the translator
// Each macro expands to a labelled concurrent assertion, or to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_TOP_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

// ===== design/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and constants of the paging translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_COUNT_DEF  = 256;
  localparam int PAGE_BYTES_DEF  = 256;
  localparam int MAX_FRAMES_DEF  = 256;
  localparam int STAMP_BITS_DEF  = 32;
  localparam int ADDR_W          = 16;
  localparam int FC_W            = 9;
  localparam int BYTE_W          = 8;
  localparam int TOT_W           = 32;
  localparam logic [TOT_W-1:0] SAT32 = '1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PTRD, ST_PTCHK, ST_SCAN, ST_SCANW, ST_EVICT, ST_OWNRD,
    ST_COMMIT, ST_DONE
  } state_t;

  // Frame memory access request from the controller
  typedef struct packed {
    logic              rd;
    logic [BYTE_W-1:0] rd_addr;
    logic              wr;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_owner;
  } frm_req_t;
endpackage

// ===== design/tlbpt_frame_mem.sv =====
// ----------------------------------------------------------------------------
// tlbpt_frame_mem
// Frame owner and stamp memory, one write and one registered read a cycle.
// Stamps reset to zero through a valid bit per frame.
// ----------------------------------------------------------------------------
module tlbpt_frame_mem
  import tlbpt_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  frm_req_t              req,
  input  logic [STAMP_BITS-1:0] wr_stamp,
  output logic [BYTE_W-1:0]     rd_owner,
  output logic [STAMP_BITS-1:0] rd_stamp
);
  localparam int FI_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [BYTE_W-1:0]     owner_mem [MAX_FRAMES];
  logic [STAMP_BITS-1:0] stamp_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] written;
  logic                  rd_written;
  logic [STAMP_BITS-1:0] stamp_q;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      owner_mem[req.wr_addr[FI_W-1:0]] <= req.wr_owner;
      stamp_mem[req.wr_addr[FI_W-1:0]] <= wr_stamp;
    end
    if (req.rd) begin
      rd_owner <= owner_mem[req.rd_addr[FI_W-1:0]];
      stamp_q  <= stamp_mem[req.rd_addr[FI_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.wr) written[req.wr_addr[FI_W-1:0]] <= 1'b1;
      if (req.rd) rd_written <= written[req.rd_addr[FI_W-1:0]];
    end
  end

  assign rd_stamp = rd_written ? stamp_q : '0;
endmodule

// ===== design/tlbpt_page_table.sv =====
// ----------------------------------------------------------------------------
// tlbpt_page_table
// Page table: frame memory with registered read, valid bits in flops.
// ----------------------------------------------------------------------------
module tlbpt_page_table
  import tlbpt_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd,
  input  logic [BYTE_W-1:0] rd_page,
  output logic              rd_valid,
  output logic [BYTE_W-1:0] rd_frame,
  input  logic              wr,
  input  logic [BYTE_W-1:0] wr_page,
  input  logic [BYTE_W-1:0] wr_frame,
  input  logic              inv,
  input  logic [BYTE_W-1:0] inv_page
);
  localparam int PI_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  logic [BYTE_W-1:0]     frame_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr) frame_mem[wr_page[PI_W-1:0]] <= wr_frame;
    if (rd) rd_frame <= frame_mem[rd_page[PI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (inv) valid[inv_page[PI_W-1:0]] <= 1'b0;
      if (wr)  valid[wr_page[PI_W-1:0]]  <= 1'b1;
      if (rd)  rd_valid <= valid[rd_page[PI_W-1:0]];
    end
  end
endmodule

// ===== design/tlb_page_table_translator_top.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator_top
// Demand-paging translator: FIFO TLB, page table, LRU frame replacement.
// ----------------------------------------------------------------------------
// Channel   | Signals                                   | Handshake
// request   | vaddr                                     | start & !busy
// result    | paddr, flags, totals                      | done, one cycle
// config    | frame_count_wdata                         | frame_count_we
//
// TLB hit: IDLE, COMMIT, DONE. Page-table hit: IDLE, PTRD, PTCHK, COMMIT, DONE.
// Fault with free frame: the same path; fault with LRU replacement: PTCHK,
// then SCAN over frame_count frames, one stamp read a cycle of the frame
// memory, then SCANW, OWNRD, EVICT, COMMIT. Reset is synchronous and
// leaves no clearing pass. The receiver cannot stall: done lasts one cycle.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_top
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [ADDR_W-1:0] vaddr,
  input  logic              frame_count_we,
  input  logic [FC_W-1:0]   frame_count_wdata,
  output logic              done,
  output logic [ADDR_W-1:0] paddr,
  output logic              tlb_hit,
  output logic              page_fault,
  output logic              replaced,
  output logic [BYTE_W-1:0] victim_page,
  output logic [TOT_W-1:0]  fault_total,
  output logic [TOT_W-1:0]  hit_total,
  output logic [TOT_W-1:0]  access_total
);
`include "tlb_page_table_translator_top_defines.svh"

  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int TI_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
  localparam logic [FC_W-1:0] MAXF = FC_W'(MAX_FRAMES);

  state_t state, state_next;

  // configuration and counters
  logic [FC_W-1:0]       frame_count;
  logic [FC_W-1:0]       free_next;
  logic [STAMP_BITS-1:0] clk_cnt;
  logic [TOT_W-1:0]      fault_cnt, hit_cnt;

  // request registers
  logic [BYTE_W-1:0] page;
  logic [OFF_W-1:0]  offset;
  logic [BYTE_W-1:0] frame;
  logic              hit_r, fault_r, repl_r;
  logic [BYTE_W-1:0] evict_r;

  // TLB in flops (small, searched in parallel)
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [BYTE_W-1:0]      tlb_page  [TLB_ENTRIES];
  logic [BYTE_W-1:0]      tlb_frame [TLB_ENTRIES];
  logic [TI_W-1:0]        tlb_fp;

  // scan state
  logic [FC_W-1:0]       scan_idx;
  logic [BYTE_W-1:0]     best_idx, last_idx;
  logic [STAMP_BITS-1:0] best_stamp;
  logic                  scan_first;

  // effective frame count
  logic [FC_W-1:0] fc;
  always_comb begin
    fc = frame_count;
    if (fc == '0) fc = FC_W'(1);
    if (fc > MAXF) fc = MAXF;
  end

  // TLB lookup on the incoming page
  logic [BYTE_W-1:0] in_page;
  logic              lk_hit;
  logic [BYTE_W-1:0] lk_frame;
  assign in_page = BYTE_W'((vaddr >> OFF_W) % PAGE_COUNT);
  always_comb begin
    lk_hit   = 1'b0;
    lk_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && tlb_page[i] == in_page) begin
        lk_hit   = 1'b1;
        lk_frame = tlb_frame[i];
      end
    end
  end

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // page table; the victim is invalidated straight from the owner read
  logic              pt_rd, pt_wr, pt_inv;
  logic              pt_rvalid;
  logic [BYTE_W-1:0] pt_rframe;
  tlbpt_page_table #(.PAGE_COUNT(PAGE_COUNT)) u_pt (
    .clk(clk), .rst(rst),
    .rd(pt_rd), .rd_page(page), .rd_valid(pt_rvalid), .rd_frame(pt_rframe),
    .wr(pt_wr), .wr_page(page), .wr_frame(frame),
    .inv(pt_inv), .inv_page(f_owner)
  );

  // frame memory
  frm_req_t              freq;
  logic [BYTE_W-1:0]     f_owner;
  logic [STAMP_BITS-1:0] f_stamp;
  tlbpt_frame_mem #(.MAX_FRAMES(MAX_FRAMES), .STAMP_BITS(STAMP_BITS)) u_frm (
    .clk(clk), .rst(rst), .req(freq), .wr_stamp(clk_cnt),
    .rd_owner(f_owner), .rd_stamp(f_stamp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = lk_hit ? ST_COMMIT : ST_PTRD;
      ST_PTRD:   state_next = ST_PTCHK;
      ST_PTCHK: begin
        if (pt_rvalid) state_next = ST_COMMIT;
        else if (free_next < fc) state_next = ST_COMMIT;
        else state_next = ST_SCAN;
      end
      ST_SCAN:   state_next = (scan_idx + FC_W'(1) >= fc) ? ST_SCANW : ST_SCAN;
      ST_SCANW:  state_next = ST_OWNRD;
      ST_OWNRD:  state_next = ST_EVICT;
      ST_EVICT:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory control outputs
  always_comb begin
    pt_rd  = (state == ST_PTRD);
    pt_wr  = (state == ST_COMMIT) && fault_r;
    pt_inv = (state == ST_EVICT);
    freq          = '0;
    freq.rd       = (state == ST_SCAN) || (state == ST_OWNRD);
    freq.rd_addr  = (state == ST_OWNRD) ? best_idx : scan_idx[BYTE_W-1:0];
    freq.wr       = (state == ST_COMMIT);
    freq.wr_addr  = frame;
    freq.wr_owner = page;
  end

  // stamp compare pipeline: data arrives in the cycle after the read
  logic                  cmp_v;
  logic [BYTE_W-1:0]     cmp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frame_count <= FC_W'(256);
      free_next   <= '0;
      clk_cnt     <= '0;
      fault_cnt   <= '0;
      hit_cnt     <= '0;
      tlb_valid   <= '0;
      tlb_fp      <= '0;
      done        <= 1'b0;
      cmp_v       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
      if (frame_count_we) frame_count <= frame_count_wdata;
      cmp_v <= (state == ST_SCAN);
      if (accept) begin
        if (clk_cnt != STAMP_MAX) clk_cnt <= clk_cnt + 1'b1;
        if (lk_hit && hit_cnt != SAT32) hit_cnt <= hit_cnt + 1'b1;
      end
      if (state == ST_PTCHK && !pt_rvalid) begin
        if (fault_cnt != SAT32) fault_cnt <= fault_cnt + 1'b1;
        if (free_next < fc) free_next <= free_next + FC_W'(1);
      end
      if (state == ST_EVICT) begin
        for (int i = 0; i < TLB_ENTRIES; i++)
          if (tlb_page[i] == f_owner) tlb_valid[i] <= 1'b0;
      end
      if (state == ST_COMMIT && !hit_r) begin
        tlb_valid[tlb_fp] <= 1'b1;
        tlb_fp <= (tlb_fp == TI_W'(TLB_ENTRIES - 1)) ? '0 : tlb_fp + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx[BYTE_W-1:0];
    if (accept) begin
      page    <= in_page;
      offset  <= vaddr[OFF_W-1:0];
      hit_r   <= lk_hit;
      frame   <= lk_frame;
      fault_r <= 1'b0;
      repl_r  <= 1'b0;
      evict_r <= '0;
    end
    case (state)
      ST_PTCHK: begin
        scan_idx   <= '0;
        scan_first <= 1'b1;
        if (pt_rvalid) frame <= pt_rframe;
        else begin
          fault_r <= 1'b1;
          frame   <= free_next[BYTE_W-1:0];
        end
      end
      ST_SCAN: scan_idx <= scan_idx + FC_W'(1);
      ST_OWNRD: repl_r <= 1'b1;
      ST_EVICT: begin
        evict_r <= f_owner;
        frame   <= best_idx;
      end
      ST_COMMIT: if (!hit_r) begin
        tlb_page[tlb_fp]  <= page;
        tlb_frame[tlb_fp] <= frame;
      end
      default: ;
    endcase
    if (cmp_v) begin
      scan_first <= 1'b0;
      if (scan_first || f_stamp < best_stamp) begin
        best_stamp <= f_stamp;
        best_idx   <= cmp_idx;
      end
    end
    if (state == ST_COMMIT) begin
      paddr       <= ADDR_W'((ADDR_W'(frame) << OFF_W) | ADDR_W'(offset));
      tlb_hit     <= hit_r;
      page_fault  <= fault_r;
      replaced    <= repl_r;
      victim_page <= repl_r ? evict_r : '0;
      last_idx    <= frame;
    end
  end

  assign fault_total  = fault_cnt;
  assign hit_total    = hit_cnt;
  assign access_total = (STAMP_BITS > TOT_W && clk_cnt > STAMP_BITS'(SAT32))
                        ? SAT32 : TOT_W'(clk_cnt);

  // checks
  `ASSERT_IMPL(a_done_after_done_state, (state == ST_DONE) |=> done)
  `ASSERT_NEVER(a_repl_without_fault, done && replaced && !page_fault)
  `ASSERT_NEVER(a_hit_and_fault, done && tlb_hit && page_fault)
  `ASSERT_IMPL(a_frame_in_range, (done && page_fault && !replaced) |-> (last_idx < MAXF))
endmodule
